// ===== hdl/segment_segment_closest_points_defines.svh =====
// Assertion macros shared by the segment closest-point design.
`ifndef SEGMENT_SEGMENT_CLOSEST_POINTS_DEFINES_SVH
`define SEGMENT_SEGMENT_CLOSEST_POINTS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SSCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SSCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sscp_pkg.sv =====
// Shared constants and types of the segment closest-point pipeline.
package sscp_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register index as decoded from paddr bit 2.
    localparam logic REG_SINGULAR_THRESHOLD = 1'b0;

    // Clamp decision for one parameter, handed to the divider.
    typedef struct packed {
        logic zero;
        logic sat;
    } t_clamp;

endpackage

// ===== hdl/segment_segment_closest_points.sv =====
// Top level: pipelined closest points between two 3D segments.
//
//  channel   handshake              payload
//  input     start / busy           i_a_*, i_b_* segment endpoints
//  result    o_valid (strobe)       o_found, o_near_a_*, o_near_b_*
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One segment pair enters every cycle; busy is never raised.
// A result's delay after its transfer is set mainly by the
// one-bit-per-stage divider that forms the two parameters.
// Synchronous reset clears the valid bits and the threshold register.
// The receiver cannot stall, so the pipeline advances on every clock.
`include "segment_segment_closest_points_defines.svh"

module segment_segment_closest_points
    import sscp_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_z,
    output logic                          o_valid,
    output logic                          o_found,
    output logic signed [COORD_WIDTH-1:0] o_near_a_x,
    output logic signed [COORD_WIDTH-1:0] o_near_a_y,
    output logic signed [COORD_WIDTH-1:0] o_near_a_z,
    output logic signed [COORD_WIDTH-1:0] o_near_b_x,
    output logic signed [COORD_WIDTH-1:0] o_near_b_y,
    output logic signed [COORD_WIDTH-1:0] o_near_b_z,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready
);
    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 2;
    localparam int MW   = 2 * SW;
    localparam int NW   = MW + 1;
    localparam int TW   = CFG_DATA_W + 3 * F + 1;
    localparam int CMPW = (NW > TW) ? NW : TW;
    localparam int LAT  = F + 10;
    localparam int GD   = F + 8;
    localparam int FD   = F + 4;

    // Dot product slots.
    localparam int BB = 0;
    localparam int DD = 1;
    localparam int BD = 2;
    localparam int BE = 3;
    localparam int DE = 4;

    logic [CFG_DATA_W-1:0] r_thr;
    logic [LAT-1:0]        r_vld;
    logic [FD-1:0]         r_fnd;

    logic signed [W-1:0]  w_as [3];
    logic signed [W-1:0]  w_ae [3];
    logic signed [W-1:0]  w_bs [3];
    logic signed [W-1:0]  w_be [3];

    logic signed [W-1:0]  r_a0 [GD][3];
    logic signed [DW-1:0] r_b  [GD][3];
    logic signed [W-1:0]  r_c0 [GD][3];
    logic signed [DW-1:0] r_d  [GD][3];
    logic signed [DW-1:0] r_e  [3];

    logic signed [PW-1:0] r_prd [5][3];
    logic signed [SW-1:0] r_dot [5];
    logic signed [MW-1:0] w_mp  [6];

    logic signed [NW-1:0] r_det;
    logic signed [NW-1:0] r_numa;
    logic signed [NW-1:0] r_numb;
    logic signed [NW-1:0] r_det7;
    logic signed [NW-1:0] r_num7a;
    logic signed [NW-1:0] r_num7b;
    t_clamp               r_clpa;
    t_clamp               r_clpb;
    logic                 w_sing;

    logic [F:0]           w_alpha;
    logic [F:0]           w_beta;
    logic signed [W-1:0]  w_na [3];
    logic signed [W-1:0]  w_nb [3];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SINGULAR_THRESHOLD) ? r_thr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_SINGULAR_THRESHOLD) begin
            r_thr <= pwdata;
        end
    end

    assign w_as = '{i_a_start_x, i_a_start_y, i_a_start_z};
    assign w_ae = '{i_a_end_x, i_a_end_y, i_a_end_z};
    assign w_bs = '{i_b_start_x, i_b_start_y, i_b_start_z};
    assign w_be = '{i_b_end_x, i_b_end_y, i_b_end_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_fnd <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start && !busy};
            r_fnd <= {r_fnd[FD-2:0], !w_sing};
        end
    end

    // Geometry pipeline: differences, dot products, then the 2x2 system.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a0[0][i] <= w_as[i];
            r_c0[0][i] <= w_bs[i];
            r_b[0][i]  <= DW'(w_ae[i]) - DW'(w_as[i]);
            r_d[0][i]  <= DW'(w_be[i]) - DW'(w_bs[i]);
            r_e[i]     <= DW'(w_as[i]) - DW'(w_bs[i]);
            for (int k = 1; k < GD; k++) begin
                r_a0[k][i] <= r_a0[k-1][i];
                r_b[k][i]  <= r_b[k-1][i];
                r_c0[k][i] <= r_c0[k-1][i];
                r_d[k][i]  <= r_d[k-1][i];
            end
            r_prd[BB][i] <= r_b[0][i] * r_b[0][i];
            r_prd[DD][i] <= r_d[0][i] * r_d[0][i];
            r_prd[BD][i] <= r_b[0][i] * r_d[0][i];
            r_prd[BE][i] <= r_b[0][i] * r_e[i];
            r_prd[DE][i] <= r_d[0][i] * r_e[i];
        end
        for (int j = 0; j < 5; j++) begin
            r_dot[j] <= SW'(r_prd[j][0]) + SW'(r_prd[j][1]) + SW'(r_prd[j][2]);
        end
        r_det   <= NW'(w_mp[0]) - NW'(w_mp[1]);
        r_numa  <= NW'(w_mp[2]) - NW'(w_mp[3]);
        r_numb  <= NW'(w_mp[4]) - NW'(w_mp[5]);
        r_det7  <= r_det;
        r_num7a <= r_numa;
        r_num7b <= r_numb;
        r_clpa  <= '{zero: (r_numa <= 0), sat: (r_det <= r_numa)};
        r_clpb  <= '{zero: (r_numb <= 0), sat: (r_det <= r_numb)};
    end

    // The threshold is in units of 2^-F, the determinant in units of 2^-4F.
    assign w_sing = CMPW'(r_det) <= $signed(CMPW'({r_thr, {(3 * F){1'b0}}}));

    sscp_mul #(.AW(SW), .BW(SW)) u_mul_det0 (
        .i_clk(i_clk), .i_a(r_dot[BB]), .i_b(r_dot[DD]), .o_p(w_mp[0]));
    sscp_mul #(.AW(SW), .BW(SW)) u_mul_det1 (
        .i_clk(i_clk), .i_a(r_dot[BD]), .i_b(r_dot[BD]), .o_p(w_mp[1]));
    sscp_mul #(.AW(SW), .BW(SW)) u_mul_na0 (
        .i_clk(i_clk), .i_a(r_dot[BD]), .i_b(r_dot[DE]), .o_p(w_mp[2]));
    sscp_mul #(.AW(SW), .BW(SW)) u_mul_na1 (
        .i_clk(i_clk), .i_a(r_dot[DD]), .i_b(r_dot[BE]), .o_p(w_mp[3]));
    sscp_mul #(.AW(SW), .BW(SW)) u_mul_nb0 (
        .i_clk(i_clk), .i_a(r_dot[BB]), .i_b(r_dot[DE]), .o_p(w_mp[4]));
    sscp_mul #(.AW(SW), .BW(SW)) u_mul_nb1 (
        .i_clk(i_clk), .i_a(r_dot[BD]), .i_b(r_dot[BE]), .o_p(w_mp[5]));

    sscp_div #(.NW(NW), .F(F)) u_div_a (
        .i_clk(i_clk), .i_num(r_num7a), .i_det(r_det7), .i_clp(r_clpa),
        .o_param(w_alpha));
    sscp_div #(.NW(NW), .F(F)) u_div_b (
        .i_clk(i_clk), .i_num(r_num7b), .i_det(r_det7), .i_clp(r_clpb),
        .o_param(w_beta));

    for (genvar g = 0; g < 3; g++) begin : g_axis
        sscp_lerp #(.W(W), .F(F)) u_lerp_a (
            .i_clk(i_clk), .i_start(r_a0[GD-1][g]), .i_delta(r_b[GD-1][g]),
            .i_param(w_alpha), .o_pt(w_na[g]));
        sscp_lerp #(.W(W), .F(F)) u_lerp_b (
            .i_clk(i_clk), .i_start(r_c0[GD-1][g]), .i_delta(r_d[GD-1][g]),
            .i_param(w_beta), .o_pt(w_nb[g]));
    end

    // A parallel pair reports zeros in every coordinate.
    assign o_valid    = r_vld[LAT-1];
    assign o_found    = r_fnd[FD-1];
    assign o_near_a_x = o_found ? w_na[0] : '0;
    assign o_near_a_y = o_found ? w_na[1] : '0;
    assign o_near_a_z = o_found ? w_na[2] : '0;
    assign o_near_b_x = o_found ? w_nb[0] : '0;
    assign o_near_b_y = o_found ? w_nb[1] : '0;
    assign o_near_b_z = o_found ? w_nb[2] : '0;

    `SSCP_ASSERT_IMP(a_latency, i_clk, i_rst_n, start && !busy, ##LAT o_valid,
        "transfer did not produce a result after the pipeline latency")
    `SSCP_ASSERT_IMP(a_parallel_zero, i_clk, i_rst_n, o_valid && !o_found,
        o_near_a_x == '0 && o_near_a_y == '0 && o_near_a_z == '0
        && o_near_b_x == '0 && o_near_b_y == '0 && o_near_b_z == '0,
        "parallel result carries non-zero coordinates")
    `SSCP_ASSERT_IMP(a_det_positive, i_clk, i_rst_n, r_vld[6] && r_fnd[0], r_det7 > 0,
        "non-singular system with a determinant at or below zero")
    `SSCP_ASSERT_IMP(a_param_range, i_clk, i_rst_n, r_vld[F+7],
        w_alpha <= ((F+1)'(1) << F) && w_beta <= ((F+1)'(1) << F),
        "segment parameter above one")

endmodule

// ===== hdl/sscp_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module sscp_mul #(
    parameter int AW = 68,
    parameter int BW = 68
) (
    input  logic                    i_clk,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int LA = AW / 2;
    localparam int LB = BW / 2;
    localparam int HA = AW - LA;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic signed [HA-1:0]      w_ah;
    logic signed [HB-1:0]      w_bh;
    logic signed [LA:0]        w_al;
    logic signed [LB:0]        w_bl;
    logic signed [HA+HB-1:0]   r_hh;
    logic signed [HA+LB:0]     r_hl;
    logic signed [LA+HB:0]     r_lh;
    logic signed [LA+LB+1:0]   r_ll;

    // Low halves are taken as unsigned, high halves carry the sign.
    assign w_ah = i_a[AW-1:LA];
    assign w_bh = i_b[BW-1:LB];
    assign w_al = {1'b0, i_a[LA-1:0]};
    assign w_bl = {1'b0, i_b[LB-1:0]};

    always_ff @(posedge i_clk) begin
        r_hh <= w_ah * w_bh;
        r_hl <= w_ah * w_bl;
        r_lh <= w_al * w_bh;
        r_ll <= w_al * w_bl;
        o_p  <= (PW'(r_hh) <<< (LA + LB)) + (PW'(r_hl) <<< LA)
              + (PW'(r_lh) <<< LB) + PW'(r_ll);
    end

endmodule

// ===== hdl/sscp_div.sv =====
// Pipelined restoring divider giving a clamped Q-format segment parameter.
module sscp_div
    import sscp_pkg::*;
#(
    parameter int NW = 137,
    parameter int F  = 16
) (
    input  logic                 i_clk,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [NW-1:0] i_det,
    input  t_clamp               i_clp,
    output logic [F:0]           o_param
);
    logic [NW-1:0] r_rem [F];
    logic [NW-1:0] r_den [F];
    logic [F-1:0]  r_quo [F];
    t_clamp        r_clp [F];
    logic [NW-1:0] w_sft [F];
    logic [NW-1:0] w_dn  [F];
    logic [F-1:0]  w_qp  [F];
    t_clamp        w_cp  [F];

    // Each stage settles one quotient bit; the remainder stays below the divisor.
    always_comb begin
        for (int k = 0; k < F; k++) begin
            if (k == 0) begin
                w_sft[k] = $unsigned(i_num) << 1;
                w_dn[k]  = $unsigned(i_det);
                w_qp[k]  = '0;
                w_cp[k]  = i_clp;
            end else begin
                w_sft[k] = r_rem[k-1] << 1;
                w_dn[k]  = r_den[k-1];
                w_qp[k]  = r_quo[k-1];
                w_cp[k]  = r_clp[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < F; k++) begin
            r_den[k] <= w_dn[k];
            r_clp[k] <= w_cp[k];
            if (w_sft[k] >= w_dn[k]) begin
                r_rem[k] <= w_sft[k] - w_dn[k];
                r_quo[k] <= {w_qp[k][F-2:0], 1'b1};
            end else begin
                r_rem[k] <= w_sft[k];
                r_quo[k] <= {w_qp[k][F-2:0], 1'b0};
            end
        end
        if (r_clp[F-1].zero) begin
            o_param <= '0;
        end else if (r_clp[F-1].sat) begin
            o_param <= (F+1)'(1) << F;
        end else begin
            o_param <= {1'b0, r_quo[F-1]};
        end
    end

endmodule

// ===== hdl/sscp_lerp.sv =====
// Two-stage interpolation of one coordinate with saturation to the coordinate range.
module sscp_lerp #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_start,
    input  logic signed [W:0]   i_delta,
    input  logic [F:0]          i_param,
    output logic signed [W-1:0] o_pt
);
    localparam int PLW  = F + W + 3;
    localparam int SUMW = PLW + 1;

    logic signed [PLW-1:0]  r_prd;
    logic signed [W-1:0]    r_st;
    logic signed [F+1:0]    w_par;
    logic signed [SUMW-1:0] w_sum;
    logic                   w_ovf;

    assign w_par = {1'b0, i_param};
    assign w_sum = SUMW'(r_st) + SUMW'(r_prd >>> F);
    // Overflow when the bits above the result's sign bit disagree with it.
    assign w_ovf = !((&w_sum[SUMW-1:W-1]) || !(|w_sum[SUMW-1:W-1]));

    always_ff @(posedge i_clk) begin
        r_prd <= w_par * i_delta;
        r_st  <= i_start;
        if (w_ovf) begin
            o_pt <= w_sum[SUMW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            o_pt <= w_sum[W-1:0];
        end
    end

endmodule

// ===== tb/sv/segment_segment_closest_points_tb.sv =====
// Self-checking testbench for the segment closest-point pipeline.
`timescale 1ns / 1ps

module segment_segment_closest_points_tb
    import sscp_pkg::*;
();

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = FB + 10;
    localparam int LIMIT    = 200000;
    localparam int N_RANDOM = 840;
    localparam int N_CALM   = 150;

    typedef logic signed [255:0] t_wide;
    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        logic   found;
        t_coord near_a[3];
        t_coord near_b[3];
    } t_connector;

    typedef struct {
        t_coord     c[12];
        bit         fixed;
        t_connector want;
    } t_pair_row;

    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_coord CMAX = 32'sh7FFF_FFFF;
    localparam t_coord CMIN = -32'sh8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_coord i_a_start_x = '0, i_a_start_y = '0, i_a_start_z = '0;
    t_coord i_a_end_x = '0, i_a_end_y = '0, i_a_end_z = '0;
    t_coord i_b_start_x = '0, i_b_start_y = '0, i_b_start_z = '0;
    t_coord i_b_end_x = '0, i_b_end_y = '0, i_b_end_z = '0;
    logic o_valid, o_found;
    t_coord o_near_a_x, o_near_a_y, o_near_a_z, o_near_b_x, o_near_b_y, o_near_b_z;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    segment_segment_closest_points dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] threshold_copy = '0;
    t_connector  pending_connectors[$];
    int          mismatches = 0;
    int          cycles = 0;

    function automatic t_wide widen(input longint v);
        t_wide w;
        w = v;
        return w;
    endfunction

    function automatic t_wide clamp_frac(input t_wide num, input t_wide det);
        if (num <= 0) return 0;
        if (num >= det) return widen(longint'(1) << FB);
        return (num <<< FB) / det;
    endfunction

    function automatic t_coord lerp_point(input t_coord s, input longint delta,
                                          input t_wide par);
        t_wide p;
        p = widen(s) + ((par * widen(delta)) >>> FB);
        if (p < widen(CMIN)) p = widen(CMIN);
        if (p > widen(CMAX)) p = widen(CMAX);
        return p[CW-1:0];
    endfunction

    function automatic t_connector closest_points(input t_coord c[12]);
        t_connector r;
        longint dir_a[3], dir_b[3], offs[3];
        t_wide aa, bb, ab, ao, bo, det, thr, alpha, beta;
        aa = 0; bb = 0; ab = 0; ao = 0; bo = 0;
        for (int i = 0; i < 3; i++) begin
            dir_a[i] = longint'(c[3+i]) - longint'(c[i]);
            dir_b[i] = longint'(c[9+i]) - longint'(c[6+i]);
            offs[i]  = longint'(c[i]) - longint'(c[6+i]);
            aa += widen(dir_a[i]) * widen(dir_a[i]);
            bb += widen(dir_b[i]) * widen(dir_b[i]);
            ab += widen(dir_a[i]) * widen(dir_b[i]);
            ao += widen(dir_a[i]) * widen(offs[i]);
            bo += widen(dir_b[i]) * widen(offs[i]);
        end
        det = aa * bb - ab * ab;
        thr = widen(longint'(threshold_copy)) <<< (3 * FB);
        r.found = 1'b0;
        for (int i = 0; i < 3; i++) begin
            r.near_a[i] = '0;
            r.near_b[i] = '0;
        end
        if (det <= thr) return r;
        alpha = clamp_frac(ab * bo - bb * ao, det);
        beta  = clamp_frac(aa * bo - ab * ao, det);
        r.found = 1'b1;
        for (int i = 0; i < 3; i++) begin
            r.near_a[i] = lerp_point(c[i], dir_a[i], alpha);
            r.near_b[i] = lerp_point(c[6+i], dir_b[i], beta);
        end
        return r;
    endfunction

    // Results are checked at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_connector w, got;
        bit bad;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            got.found = o_found;
            got.near_a = '{o_near_a_x, o_near_a_y, o_near_a_z};
            got.near_b = '{o_near_b_x, o_near_b_y, o_near_b_z};
            if (pending_connectors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                w = pending_connectors.pop_front();
                bad = (w.found !== got.found);
                for (int i = 0; i < 3; i++)
                    bad |= (w.near_a[i] !== got.near_a[i])
                        || (w.near_b[i] !== got.near_b[i]);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected %0b a(%0d %0d %0d) b(%0d %0d %0d),",
                                  " got %0b a(%0d %0d %0d) b(%0d %0d %0d)"},
                            w.found, w.near_a[0], w.near_a[1], w.near_a[2],
                            w.near_b[0], w.near_b[1], w.near_b[2],
                            got.found, got.near_a[0], got.near_a[1], got.near_a[2],
                            got.near_b[0], got.near_b[1], got.near_b[2]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SINGULAR_THRESHOLD) threshold_copy = value;
        @(posedge i_clk);
    endtask

    // Configuration only changes once the pipeline has drained.
    task automatic drain_and_set(input logic [31:0] value);
        start <= 1'b0;
        while (pending_connectors.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        reg_write(REG_SINGULAR_THRESHOLD, value);
    endtask

    // Drives one pair and holds it until the transfer; start stays high afterwards.
    task automatic send_pair(input t_coord c[12], input bit fixed, input t_connector want);
        {i_a_start_x, i_a_start_y, i_a_start_z} <= {c[0], c[1], c[2]};
        {i_a_end_x, i_a_end_y, i_a_end_z}       <= {c[3], c[4], c[5]};
        {i_b_start_x, i_b_start_y, i_b_start_z} <= {c[6], c[7], c[8]};
        {i_b_end_x, i_b_end_y, i_b_end_z}       <= {c[9], c[10], c[11]};
        start <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_connectors = {pending_connectors, (fixed ? want : closest_points(c))};
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    function automatic t_coord rand_coord(input int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    function automatic void random_pair(output t_coord c[12]);
        int kind, mag;
        kind = $urandom_range(0, 9);
        mag  = $urandom_range(0, 2);
        for (int i = 0; i < 12; i++) c[i] = rand_coord(mag);
        if (kind < 2) begin
            // Nearly parallel: B is A shifted, with a tiny twist.
            for (int i = 0; i < 3; i++) begin
                c[6+i] = c[i] + rand_coord(1);
                c[9+i] = c[6+i] + (c[3+i] - c[i]) + $signed($urandom_range(0, 8)) - 4;
            end
        end else if (kind == 2) begin
            for (int i = 0; i < 3; i++) c[3+i] = c[i];
        end else if (kind == 3) begin
            for (int i = 0; i < 3; i++) c[9+i] = c[6+i];
        end
    endfunction

    t_pair_row directed[$];

    function automatic t_pair_row mk(input t_coord c[12]);
        t_pair_row r;
        r.c = c;
        r.fixed = 1'b0;
        r.want.found = 1'b0;
        r.want.near_a = '{0, 0, 0};
        r.want.near_b = '{0, 0, 0};
        return r;
    endfunction

    initial begin
        t_pair_row row;
        t_coord c[12];
        logic [31:0] thresholds[5];
        t_connector none;

        none.found = 1'b0;
        none.near_a = '{0, 0, 0};
        none.near_b = '{0, 0, 0};

        // Zero-length segments and identical segments are singular.
        row = mk('{default: 0}); row.fixed = 1; directed = {directed, row};
        row = mk('{default: CMAX}); row.fixed = 1; directed = {directed, row};
        row = mk('{default: CMIN}); row.fixed = 1; directed = {directed, row};
        row = mk('{0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 0}); row.fixed = 1;
        directed = {directed, row};
        // Parallel but offset.
        row = mk('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2*ONE, ONE, 0}); row.fixed = 1;
        directed = {directed, row};
        // Perpendicular crossing, one unit apart in z.
        row = mk('{-ONE, 0, 0, ONE, 0, 0, 0, -ONE, ONE, 0, ONE, ONE});
        row.fixed = 1;
        row.want.found = 1'b1;
        row.want.near_a = '{0, 0, 0};
        row.want.near_b = '{0, 0, ONE};
        directed = {directed, row};
        // Both parameters clamp to 0, then alpha clamps to 1 and beta to 0.
        directed = {directed, mk('{0, 0, 0, ONE, 0, 0, -ONE, -ONE, 0, -ONE, -2*ONE, ONE})};
        directed = {directed, mk('{0, 0, 0, ONE, 0, 0, 2*ONE, ONE, 0, 2*ONE, 2*ONE, ONE})};
        // Interior skew case with a non-trivial fraction.
        directed = {directed, mk('{0, 0, 0, 3*ONE, ONE, 0, ONE, -2*ONE, ONE, 0, 3*ONE, -ONE})};
        // Coordinate extremes.
        directed = {directed, mk('{CMIN, 0, 0, CMAX, 0, 0, 0, CMIN, CMAX, 0, CMAX, CMIN})};
        directed = {directed, mk('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                                   CMIN, CMIN, CMAX, CMAX, CMAX, CMIN})};
        directed = {directed, mk('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                   CMAX, CMIN, CMIN, CMIN, CMAX, CMAX})};
        directed = {directed, mk('{CMAX, 0, CMIN, CMAX, 1, CMIN,
                                   CMIN, CMAX, 0, CMIN, CMAX, 1})};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_pair(directed[k].c, directed[k].fixed,
                      directed[k].fixed ? directed[k].want : none);
            maybe_pause();
        end

        // Register index one does not exist; a write there must change nothing.
        drain_and_set(32'd0);
        reg_write(~REG_SINGULAR_THRESHOLD, $urandom);

        thresholds = '{32'd1, 32'hFFFF_FFFF, $urandom, 32'd65536, 32'd0};
        for (int ph = 0; ph < 5; ph++) begin
            drain_and_set(thresholds[ph]);
            // The crossing case is sent again under each threshold.
            send_pair(directed[5].c, 1'b0, none);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                random_pair(c);
                send_pair(c, 1'b0, none);
                if (ph < 4 || n < N_RANDOM / 5 - N_CALM) maybe_pause();
            end
        end
        start <= 1'b0;

        while (pending_connectors.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
